@@ rtl/ffra_pkg.sv @@
// ffra_pkg: shared constants, codes and control/status types of the
// first-fit range allocator. Used by ffra_ctrl, ffra_dp and the top level.
package ffra_pkg;

  localparam int HEAP_BYTES = 64 * 1024;
  localparam int MAX_RANGES = 64;
  localparam int WORD_BYTES = 8;
  localparam int MIN_BLOCK  = 2 * WORD_BYTES;

  localparam int ADDR_W = 16;                       // address field
  localparam int LEN_W  = 17;                       // length field
  localparam int SUM_W  = 18;                       // sums of address and length
  localparam int CNT_W  = $clog2(MAX_RANGES + 1);   // range count / index
  localparam int MEM_AW = $clog2(MAX_RANGES);       // table address

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_AT    = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_BAD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {RD_IDX, RD_INC, RD_DEC} rd_sel_t;

  typedef enum logic [3:0] {
    W_INIT, W_MOVE, W_SPLIT, W_AT_HEAD, W_GAP, W_FRONT, W_NEWR, W_EXT, W_MERGE
  } wsrc_t;

  typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_CNT} idx_op_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic [1:0] {INS_HOLD, INS_IDX, INS_IDX1} ins_op_t;
  typedef enum logic [2:0] {N_HOLD, N_ALLOC, N_ROUND, N_RAW, N_AVAIL} n_op_t;
  typedef enum logic [1:0] {RA_ZERO, RA_RS, RA_ADDR} res_a_t;
  typedef enum logic [1:0] {RS_ZERO, RS_RL, RS_N, RS_NEFF} res_s_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    logic    we;
    wsrc_t   wsrc;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    ins_op_t ins_op;
    n_op_t   n_op;
    logic    latch_in;
    logic    latch_cur;
    logic    calc;
    logic    res_set;
    res_a_t  res_a;
    res_s_t  res_s;
    status_t res_st;
  } cmd_t;

  typedef struct packed {
    logic a_mis;
    logic sz_zero;
    logic free_bad;
    logic idx_end;
    logic full;
    logic next_exists;
    logic add_more;
    logic fit;
    logic fit_small;
    logic a_lt_s;
    logic a_lt_end;
    logic a_le_end;
    logic bn_gt_s;
    logic bn_eq_s;
    logic av_lt_n;
    logic gap_bad;
    logic gap_zero;
    logic tail_small;
    logic n_ge;
  } stat_t;

endpackage

@@ rtl/ffra_dp.sv @@
// ffra_dp: datapath of the allocator - range table memory, request
// registers, compare flags and result registers. Depends on ffra_pkg.
module ffra_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [39:0]              s_tdata,
  input  ffra_pkg::cmd_t           cmd,
  output ffra_pkg::stat_t          st,
  output logic [ffra_pkg::ADDR_W-1:0] res_addr,
  output logic [ffra_pkg::LEN_W-1:0]  res_size,
  output ffra_pkg::status_t        res_st
);
  import ffra_pkg::*;

  logic [ADDR_W-1:0] mem_s [MAX_RANGES];
  logic [LEN_W-1:0]  mem_l [MAX_RANGES];
  logic [ADDR_W-1:0] rd_s;
  logic [LEN_W-1:0]  rd_l;

  logic [ADDR_W-1:0] a_r;
  logic [LEN_W-1:0]  sz_r;
  logic [SUM_W-1:0]  nreg;
  logic [ADDR_W-1:0] cur_s;
  logic [LEN_W-1:0]  cur_l;
  logic [LEN_W-1:0]  cur_end;
  logic [LEN_W-1:0]  avail;
  logic [ADDR_W-1:0] gap;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  ins;

  logic [MEM_AW-1:0] raddr;
  logic [MEM_AW-1:0] waddr;
  logic [ADDR_W-1:0] wr_s;
  logic [LEN_W-1:0]  wr_l;

  logic [SUM_W-1:0]  a18, sz18, rs18, rl18, av18, cl18;
  logic [SUM_W-1:0]  rnd, n_al, rend, bn, neff;
  logic [SUM_W-1:0]  sum_split_s, sum_head_s, sum_front_l, sum_ext_l, sum_merge_l;
  logic [SUM_W-1:0]  dif_split_l, dif_head_l;
  logic [CNT_W:0]    idx_p1;

  assign a18  = {{(SUM_W-ADDR_W){1'b0}}, a_r};
  assign sz18 = {{(SUM_W-LEN_W){1'b0}}, sz_r};
  assign rs18 = {{(SUM_W-ADDR_W){1'b0}}, rd_s};
  assign rl18 = {{(SUM_W-LEN_W){1'b0}}, rd_l};
  assign av18 = {{(SUM_W-LEN_W){1'b0}}, avail};
  assign cl18 = {{(SUM_W-LEN_W){1'b0}}, cur_l};

  // size rounded up to whole words, floor of two words for first fit
  assign rnd  = (sz18 + SUM_W'(WORD_BYTES - 1)) & ~SUM_W'(WORD_BYTES - 1);
  assign n_al = (rnd < SUM_W'(MIN_BLOCK)) ? SUM_W'(MIN_BLOCK) : rnd;

  assign rend = rs18 + rl18;
  assign bn   = a18 + nreg;
  assign neff = st.tail_small ? av18 : nreg;

  assign sum_split_s = rs18 + nreg;
  assign dif_split_l = rl18 - nreg;
  assign sum_head_s  = a18 + nreg;
  assign dif_head_l  = av18 - nreg;
  assign sum_front_l = rl18 + nreg;
  assign sum_ext_l   = cl18 + nreg;
  assign sum_merge_l = cl18 + nreg + rl18;
  assign idx_p1      = {1'b0, idx} + (CNT_W+1)'(1);

  always_comb begin
    st             = '0;
    st.a_mis       = a_r[$clog2(WORD_BYTES)-1:0] != '0;
    st.sz_zero     = sz_r == '0;
    st.free_bad    = (sz_r[$clog2(WORD_BYTES)-1:0] != '0) || (sz18 < SUM_W'(MIN_BLOCK)) ||
                     st.a_mis || ((a18 + sz18) > SUM_W'(HEAP_BYTES));
    st.idx_end     = idx >= cnt;
    st.full        = cnt == CNT_W'(MAX_RANGES);
    st.next_exists = idx_p1 < {1'b0, cnt};
    st.add_more    = idx > ins;
    st.fit         = rl18 >= nreg;
    st.fit_small   = dif_split_l < SUM_W'(MIN_BLOCK);
    st.a_lt_s      = a_r < rd_s;
    st.a_lt_end    = a18 < rend;
    st.a_le_end    = a18 <= rend;
    st.bn_gt_s     = bn > rs18;
    st.bn_eq_s     = bn == rs18;
    st.av_lt_n     = av18 < nreg;
    st.gap_zero    = gap == '0;
    st.gap_bad     = !st.gap_zero && (gap < ADDR_W'(MIN_BLOCK));
    st.tail_small  = (av18 > nreg) && (dif_head_l < SUM_W'(MIN_BLOCK));
    st.n_ge        = nreg >= av18;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_INC:  raddr = idx_p1[MEM_AW-1:0];
      RD_DEC:  raddr = MEM_AW'(idx - CNT_W'(1));
      default: raddr = idx[MEM_AW-1:0];
    endcase
  end

  assign waddr = idx[MEM_AW-1:0];

  always_comb begin
    case (cmd.wsrc)
      W_INIT:    begin wr_s = '0;    wr_l = LEN_W'(HEAP_BYTES); end
      W_MOVE:    begin wr_s = rd_s;  wr_l = rd_l; end
      W_SPLIT:   begin wr_s = sum_split_s[ADDR_W-1:0]; wr_l = dif_split_l[LEN_W-1:0]; end
      W_AT_HEAD: begin wr_s = sum_head_s[ADDR_W-1:0];  wr_l = dif_head_l[LEN_W-1:0]; end
      W_GAP:     begin wr_s = cur_s; wr_l = {1'b0, gap}; end
      W_FRONT:   begin wr_s = a_r;   wr_l = sum_front_l[LEN_W-1:0]; end
      W_NEWR:    begin wr_s = a_r;   wr_l = nreg[LEN_W-1:0]; end
      W_EXT:     begin wr_s = cur_s; wr_l = sum_ext_l[LEN_W-1:0]; end
      W_MERGE:   begin wr_s = cur_s; wr_l = sum_merge_l[LEN_W-1:0]; end
      default:   begin wr_s = rd_s;  wr_l = rd_l; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem_s[waddr] <= wr_s;
      mem_l[waddr] <= wr_l;
    end
    rd_s <= mem_s[raddr];
    rd_l <= mem_l[raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_r  <= s_tdata[15:0];
      sz_r <= s_tdata[32:16];
    end
    case (cmd.n_op)
      N_ALLOC: nreg <= n_al;
      N_ROUND: nreg <= rnd;
      N_RAW:   nreg <= sz18;
      N_AVAIL: nreg <= av18;
      default: nreg <= nreg;
    endcase
    if (cmd.latch_cur) begin
      cur_s   <= rd_s;
      cur_l   <= rd_l;
      cur_end <= rend[LEN_W-1:0];
    end
    if (cmd.calc) begin
      avail <= cur_end - {1'b0, a_r};
      gap   <= a_r - cur_s;
    end
    if (cmd.res_set) begin
      case (cmd.res_a)
        RA_RS:   res_addr <= rd_s;
        RA_ADDR: res_addr <= a_r;
        default: res_addr <= '0;
      endcase
      case (cmd.res_s)
        RS_RL:   res_size <= rd_l;
        RS_N:    res_size <= nreg[LEN_W-1:0];
        RS_NEFF: res_size <= neff[LEN_W-1:0];
        default: res_size <= '0;
      endcase
      res_st <= cmd.res_st;
    end
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cnt <= CNT_W'(1);
      ins <= '0;
    end else begin
      case (cmd.idx_op)
        IDX_ZERO: idx <= '0;
        IDX_INC:  idx <= idx + CNT_W'(1);
        IDX_DEC:  idx <= idx - CNT_W'(1);
        IDX_CNT:  idx <= cnt;
        default:  idx <= idx;
      endcase
      case (cmd.cnt_op)
        CNT_INC: cnt <= cnt + CNT_W'(1);
        CNT_DEC: cnt <= cnt - CNT_W'(1);
        default: cnt <= cnt;
      endcase
      case (cmd.ins_op)
        INS_IDX:  ins <= idx;
        INS_IDX1: ins <= idx_p1[CNT_W-1:0];
        default:  ins <= ins;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RANGES)) else $error("range count beyond table depth");
  a_grow_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == CNT_INC |-> !st.full) else $error("insert into full table");
  a_shrink: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == CNT_DEC |-> cnt != '0) else $error("drop from empty table");
  a_wr_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.we |-> idx < CNT_W'(MAX_RANGES)) else $error("table write out of range");

endmodule

@@ rtl/ffra_ctrl.sv @@
// ffra_ctrl: sequencer of the allocator - scans the range table, drives
// shifts and writes in ffra_dp, runs the handshakes. Depends on ffra_pkg.
module ffra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic [1:0]           s_tuser,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  ffra_pkg::stat_t      st,
  output ffra_pkg::cmd_t       cmd
);
  import ffra_pkg::*;

  typedef enum logic [13:0] {
    S_INIT       = 14'b00000000000001,
    S_IDLE       = 14'b00000000000010,
    S_DISP       = 14'b00000000000100,
    S_LOAD       = 14'b00000000001000,
    S_CHECK      = 14'b00000000010000,
    S_AT_CALC    = 14'b00000000100000,
    S_AT_DEC     = 14'b00000001000000,
    S_NEXT_LOAD  = 14'b00000010000000,
    S_NEXT_CHECK = 14'b00000100000000,
    S_DROP_TEST  = 14'b00001000000000,
    S_DROP_WR    = 14'b00010000000000,
    S_ADD_TEST   = 14'b00100000000000,
    S_ADD_WR     = 14'b01000000000000,
    S_RESP       = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  req_t   req;

  function automatic cmd_t answer(cmd_t c, res_a_t ra, res_s_t rs, status_t code);
    cmd_t r;
    r         = c;
    r.res_set = 1'b1;
    r.res_a   = ra;
    r.res_s   = rs;
    r.res_st  = code;
    return r;
  endfunction

  assign s_tready = state == S_IDLE;
  assign m_tvalid = state == S_RESP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      req   <= REQ_ALLOC;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) req <= req_t'(s_tuser);
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    cmd.wsrc   = W_MOVE;
    cmd.idx_op = IDX_HOLD;
    cmd.cnt_op = CNT_HOLD;
    cmd.ins_op = INS_HOLD;
    cmd.n_op   = N_HOLD;
    cmd.res_a  = RA_ZERO;
    cmd.res_s  = RS_ZERO;
    cmd.res_st = ST_OK;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.we     = 1'b1;
        cmd.wsrc   = W_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.latch_in = 1'b1;
        if (s_tvalid) state_next = S_DISP;
      end
      S_DISP: begin
        cmd.idx_op = IDX_ZERO;
        state_next = S_LOAD;
        case (req)
          REQ_ALLOC: cmd.n_op = N_ALLOC;
          REQ_AT: begin
            cmd.n_op = N_ROUND;
            if (st.a_mis || st.sz_zero) begin
              cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_REJECT);
              state_next = S_RESP;
            end
          end
          REQ_FREE: begin
            cmd.n_op = N_RAW;
            if (st.sz_zero) begin
              cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_OK);
              state_next = S_RESP;
            end else if (st.free_bad) begin
              cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_REJECT);
              state_next = S_RESP;
            end
          end
          default: begin
            cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_REJECT);
            state_next = S_RESP;
          end
        endcase
      end
      S_LOAD: begin
        if (!st.idx_end) begin
          state_next = S_CHECK;
        end else if (req != REQ_FREE) begin
          cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_NOFIT);
          state_next = S_RESP;
        end else if (st.full) begin
          cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_FULL);
          state_next = S_RESP;
        end else begin
          // append past the last range: idx already equals the count
          cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_OK);
          cmd.ins_op = INS_IDX;
          state_next = S_ADD_TEST;
        end
      end
      S_CHECK: begin
        cmd.latch_cur = 1'b1;
        cmd.idx_op    = IDX_INC;
        state_next    = S_LOAD;
        case (req)
          REQ_ALLOC: begin
            if (st.fit) begin
              cmd.idx_op = IDX_HOLD;
              if (st.fit_small) begin
                cmd        = answer(cmd, RA_RS, RS_RL, ST_OK);
                state_next = S_DROP_TEST;
              end else begin
                cmd        = answer(cmd, RA_RS, RS_N, ST_OK);
                cmd.we     = 1'b1;
                cmd.wsrc   = W_SPLIT;
                state_next = S_RESP;
              end
            end
          end
          REQ_AT: begin
            if (st.a_lt_s) begin
              cmd.idx_op = IDX_HOLD;
              cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_NOFIT);
              state_next = S_RESP;
            end else if (st.a_lt_end) begin
              cmd.idx_op = IDX_HOLD;
              state_next = S_AT_CALC;
            end
          end
          default: begin
            if (st.a_le_end) begin
              cmd.idx_op = IDX_HOLD;
              if (!st.a_lt_end) begin
                // released block starts right at the end of this range
                state_next = S_NEXT_LOAD;
              end else if (st.bn_gt_s) begin
                cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_REJECT);
                state_next = S_RESP;
              end else if (st.bn_eq_s) begin
                cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_OK);
                cmd.we     = 1'b1;
                cmd.wsrc   = W_FRONT;
                state_next = S_RESP;
              end else if (st.full) begin
                cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_FULL);
                state_next = S_RESP;
              end else begin
                cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_OK);
                cmd.ins_op = INS_IDX;
                cmd.idx_op = IDX_CNT;
                state_next = S_ADD_TEST;
              end
            end
          end
        endcase
      end
      S_AT_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_AT_DEC;
      end
      S_AT_DEC: begin
        state_next = S_RESP;
        if (st.av_lt_n) begin
          cmd = answer(cmd, RA_ZERO, RS_ZERO, ST_NOFIT);
        end else if (st.gap_bad) begin
          cmd = answer(cmd, RA_ZERO, RS_ZERO, ST_REJECT);
        end else begin
          cmd = answer(cmd, RA_ADDR, RS_NEFF, ST_OK);
          if (st.tail_small) cmd.n_op = N_AVAIL;
          if (st.gap_zero) begin
            if (st.n_ge || st.tail_small) begin
              state_next = S_DROP_TEST;
            end else begin
              cmd.we   = 1'b1;
              cmd.wsrc = W_AT_HEAD;
            end
          end else if (st.n_ge || st.tail_small) begin
            cmd.we   = 1'b1;
            cmd.wsrc = W_GAP;
          end else if (st.full) begin
            cmd = answer(cmd, RA_ZERO, RS_ZERO, ST_FULL);
          end else begin
            // keep the gap here, the tail goes in one slot up
            cmd.we     = 1'b1;
            cmd.wsrc   = W_GAP;
            cmd.ins_op = INS_IDX1;
            cmd.idx_op = IDX_CNT;
            state_next = S_ADD_TEST;
          end
        end
      end
      S_NEXT_LOAD: begin
        cmd.rd_sel = RD_INC;
        if (st.next_exists) begin
          state_next = S_NEXT_CHECK;
        end else begin
          cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_OK);
          cmd.we     = 1'b1;
          cmd.wsrc   = W_EXT;
          state_next = S_RESP;
        end
      end
      S_NEXT_CHECK: begin
        state_next = S_RESP;
        if (st.bn_gt_s) begin
          cmd = answer(cmd, RA_ZERO, RS_ZERO, ST_REJECT);
        end else if (st.bn_eq_s) begin
          cmd        = answer(cmd, RA_ZERO, RS_ZERO, ST_OK);
          cmd.we     = 1'b1;
          cmd.wsrc   = W_MERGE;
          cmd.idx_op = IDX_INC;
          state_next = S_DROP_TEST;
        end else begin
          cmd      = answer(cmd, RA_ZERO, RS_ZERO, ST_OK);
          cmd.we   = 1'b1;
          cmd.wsrc = W_EXT;
        end
      end
      S_DROP_TEST: begin
        cmd.rd_sel = RD_INC;
        if (st.next_exists) begin
          state_next = S_DROP_WR;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_RESP;
        end
      end
      S_DROP_WR: begin
        cmd.we     = 1'b1;
        cmd.wsrc   = W_MOVE;
        cmd.idx_op = IDX_INC;
        state_next = S_DROP_TEST;
      end
      S_ADD_TEST: begin
        cmd.rd_sel = RD_DEC;
        if (st.add_more) begin
          state_next = S_ADD_WR;
        end else begin
          cmd.we     = 1'b1;
          cmd.wsrc   = (req == REQ_AT) ? W_AT_HEAD : W_NEWR;
          cmd.cnt_op = CNT_INC;
          state_next = S_RESP;
        end
      end
      S_ADD_WR: begin
        cmd.we     = 1'b1;
        cmd.wsrc   = W_MOVE;
        cmd.idx_op = IDX_DEC;
        state_next = S_ADD_TEST;
      end
      S_RESP: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input and output open together");
  a_result_set: assert property (@(posedge clk) disable iff (rst)
    (state_next == S_RESP && state != S_RESP && state != S_DROP_TEST &&
     state != S_ADD_TEST) |-> cmd.res_set) else $error("result not loaded");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESP) |-> !cmd.we) else $error("table write at rest");

endmodule

@@ rtl/first_fit_range_allocator_unit.sv @@
// first_fit_range_allocator_unit: top level of the first-fit range allocator.
// Instantiates ffra_ctrl and ffra_dp; depends on ffra_pkg.
//
//  channel  dir  signals                        beat content
//  s_       in   tvalid tready tdata tuser      request: tuser req_type, tdata address/size
//  m_       out  tvalid tready tdata tuser      result:  tdata address/granted size, tuser status
//
// One request at a time. The table is scanned one entry after another, and on insert or
// removal entries are shifted one slot at a time; scanned and shifted entries together
// never exceed the range count.
// After rst the S_INIT state writes the initial range before s_tready rises.
// A result waits in its register while m_tready is low; no new beat is taken then.
module first_fit_range_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] address, [32:16] size_bytes, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] result_address, [32:16] granted_size, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import ffra_pkg::*;

  cmd_t              cmd;
  stat_t             st;
  logic [ADDR_W-1:0] res_addr;
  logic [LEN_W-1:0]  res_size;
  status_t           res_st;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ffra_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .st       (st),
    .res_addr (res_addr),
    .res_size (res_size),
    .res_st   (res_st)
  );

  assign m_tdata = {7'd0, res_size, res_addr};
  assign m_tuser = res_st;

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for first_fit_range_allocator_unit.
// Keeps its own free-range table, drives requests on the s_ stream, checks m_ beats.
// Depends on ffra_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;
  import ffra_pkg::*;

  typedef struct packed {
    req_t        kind;
    logic [15:0] addr;
    logic [16:0] size;
  } alloc_req_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [16:0] granted;
    status_t     st;
  } alloc_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  first_fit_range_allocator_unit u_top (.*);

  always #1 clk = ~clk;

  // allocator shadow state
  int unsigned free_start[MAX_RANGES];
  int unsigned free_len[MAX_RANGES];
  int unsigned free_cnt;

  alloc_req_t  pending_reqs[$];
  alloc_res_t  expected_res[$];
  int          errors = 0;
  int          n_sent = 0, n_checked = 0, n_ok = 0, n_full = 0;
  bit          stim_done = 0;
  bit          hold_off = 0;
  bit          calm = 0;
  int          idle_cnt = 0;
  localparam int IDLE_LIMIT = 20000;

  function automatic int unsigned round8(int unsigned v);
    return (v % WORD_BYTES) ? v + (WORD_BYTES - v % WORD_BYTES) : v;
  endfunction

  function automatic void remove_range(int unsigned i);
    for (int unsigned k = i; k + 1 < free_cnt; k++) begin
      free_start[k] = free_start[k + 1];
      free_len[k]   = free_len[k + 1];
    end
    free_cnt--;
    free_start[free_cnt] = 0;
    free_len[free_cnt]   = 0;
  endfunction

  function automatic bit insert_range(int unsigned i, int unsigned s, int unsigned l);
    if (free_cnt >= MAX_RANGES) return 0;
    for (int unsigned k = free_cnt; k > i; k--) begin
      free_start[k] = free_start[k - 1];
      free_len[k]   = free_len[k - 1];
    end
    free_start[i] = s;
    free_len[i]   = l;
    free_cnt++;
    return 1;
  endfunction

  function automatic alloc_res_t outcome(int unsigned a, int unsigned g, status_t st);
    alloc_res_t r;
    r.addr = a[15:0];
    r.granted = g[16:0];
    r.st = st;
    return r;
  endfunction

  function automatic alloc_res_t serve_request(alloc_req_t q);
    int unsigned a, n, i, e, avail, gap, rem, s, g;
    a = q.addr;
    n = q.size;
    case (q.kind)
      REQ_ALLOC: begin
        n = round8(n);
        if (n < MIN_BLOCK) n = MIN_BLOCK;
        for (i = 0; i < free_cnt; i++) begin
          if (free_len[i] >= n) begin
            s = free_start[i];
            rem = free_len[i] - n;
            if (rem < MIN_BLOCK) begin
              g = free_len[i];
              remove_range(i);
            end else begin
              g = n;
              free_start[i] = s + n;
              free_len[i] = rem;
            end
            return outcome(s, g, ST_OK);
          end
        end
        return outcome(0, 0, ST_NOFIT);
      end
      REQ_AT: begin
        if (a % WORD_BYTES) return outcome(0, 0, ST_REJECT);
        n = round8(n);
        if (n == 0) return outcome(0, 0, ST_REJECT);
        for (i = 0; i < free_cnt; i++) begin
          if (a < free_start[i]) return outcome(0, 0, ST_NOFIT);
          if (a < free_start[i] + free_len[i]) break;
        end
        if (i >= free_cnt) return outcome(0, 0, ST_NOFIT);
        e = free_start[i] + free_len[i];
        avail = e - a;
        if (avail < n) return outcome(0, 0, ST_NOFIT);
        gap = a - free_start[i];
        if (gap != 0 && gap < MIN_BLOCK) return outcome(0, 0, ST_REJECT);
        if (avail > n && avail - n < MIN_BLOCK) n = avail;
        if (gap == 0) begin
          if (n >= avail) remove_range(i);
          else begin
            free_start[i] = a + n;
            free_len[i] = avail - n;
          end
        end else if (n >= avail) begin
          free_len[i] = gap;
        end else begin
          if (!insert_range(i + 1, a + n, avail - n)) return outcome(0, 0, ST_FULL);
          free_len[i] = gap;
        end
        return outcome(a, n, ST_OK);
      end
      REQ_FREE: begin
        if (n == 0) return outcome(0, 0, ST_OK);
        if (n % WORD_BYTES || n < MIN_BLOCK || a % WORD_BYTES || a + n > HEAP_BYTES)
          return outcome(0, 0, ST_REJECT);
        for (i = 0; i < free_cnt; i++) begin
          if (a < free_start[i] + free_len[i]) begin
            if (a + n > free_start[i]) return outcome(0, 0, ST_REJECT);
            break;
          end
        end
        for (i = 0; i < free_cnt; i++)
          if (a <= free_start[i] + free_len[i]) break;
        if (i >= free_cnt) begin
          if (!insert_range(free_cnt, a, n)) return outcome(0, 0, ST_FULL);
        end else if (a == free_start[i] + free_len[i]) begin
          free_len[i] += n;
          if (i + 1 < free_cnt && free_start[i + 1] == free_start[i] + free_len[i]) begin
            free_len[i] += free_len[i + 1];
            remove_range(i + 1);
          end
        end else if (a + n == free_start[i]) begin
          free_start[i] = a;
          free_len[i] += n;
        end else if (!insert_range(i, a, n)) begin
          return outcome(0, 0, ST_FULL);
        end
        return outcome(0, 0, ST_OK);
      end
      default: return outcome(0, 0, ST_REJECT);
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_checked);
  endtask

  function automatic void push(req_t k, int unsigned a, int unsigned s);
    alloc_req_t q;
    q.kind = k;
    q.addr = a[15:0];
    q.size = s[16:0];
    pending_reqs.push_back(q);
  endfunction

  // sampled handshake for the driver
  logic s_tready_q = 1'b0;
  always @(posedge clk) s_tready_q <= s_tvalid && s_tready;

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
          alloc_req_t q;
          q = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= q.kind;
          s_tdata  <= {7'd0, q.size, q.addr};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !hold_off && (calm || $urandom_range(99) >= 11);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (s_tvalid && s_tready) begin
        alloc_req_t q;
        q.kind = req_t'(s_tuser);
        q.addr = s_tdata[15:0];
        q.size = s_tdata[32:16];
        expected_res.push_back(serve_request(q));
        n_sent++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_res.size() == 0) begin
          errors++;
          $display("unexpected result beat");
        end else begin
          alloc_res_t w;
          w = expected_res.pop_front();
          if (m_tdata[15:0] !== w.addr) report("result_address", m_tdata[15:0], w.addr);
          if (m_tdata[32:16] !== w.granted) report("granted_size", m_tdata[32:16], w.granted);
          if (m_tdata[39:33] !== 7'd0) report("tdata pad", m_tdata[39:33], 0);
          if (m_tuser !== w.st) report("status", m_tuser, w.st);
          if (w.st == ST_OK) n_ok++;
          if (w.st == ST_FULL) n_full++;
        end
        n_checked++;
      end
      if (idle_cnt >= IDLE_LIMIT && !hold_off) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // long receiver hold-off once, mid-run
  initial begin
    wait (n_sent == 600);
    @(negedge clk);
    hold_off = 1;
    repeat (3000) @(posedge clk);
    @(negedge clk);
    hold_off = 0;
  end

  initial begin
    int unsigned s, k;
    free_cnt = 1;
    for (int i = 0; i < MAX_RANGES; i++) begin
      free_start[i] = 0;
      free_len[i] = 0;
    end
    free_len[0] = HEAP_BYTES;

    // directed corner cases
    push(REQ_ALLOC, 0, 0);          // minimum block
    push(REQ_ALLOC, 16'hFFFF, 1);   // rounds up
    push(REQ_ALLOC, 0, 65536);      // too big now
    push(REQ_AT, 3, 32);            // misaligned
    push(REQ_AT, 64, 0);            // zero size
    push(REQ_AT, 40, 16);           // gap below 16
    push(REQ_AT, 0, 16);            // already taken
    push(REQ_AT, 128, 40);          // middle split
    push(REQ_AT, 168, 65368);       // exact fit at range start, range removed
    push(REQ_AT, 65520, 8);         // tail of heap, already taken: nofit
    push(REQ_FREE, 0, 0);           // no-op
    push(REQ_FREE, 0, 12);          // not word multiple
    push(REQ_FREE, 0, 8);           // under minimum
    push(REQ_FREE, 4, 16);          // misaligned
    push(REQ_FREE, 65528, 16);      // beyond heap
    push(REQ_FREE, 256, 64);        // new separate range past the free space
    push(REQ_FREE, 0, 16);          // separate range below the first
    push(REQ_FREE, 128, 40);        // merge with the range below
    push(REQ_BAD, 16'hFFFF, 17'h1FFFF);
    push(REQ_ALLOC, 0, 65536);      // whole heap
    push(REQ_ALLOC, 0, 16);         // takes the first range whole
    push(REQ_FREE, 65520, 16);      // new range at end
    push(REQ_FREE, 0, 65536);       // overlap
    push(REQ_FREE, 32, 32);         // overlaps free space
    push(REQ_FREE, 96, 17'h10000 - 96 - 16 - 8); // odd-word size, overlaps free space: reject

    // fragment the heap to fill the table: alternating at-allocations
    for (k = 0; k < 70; k++) push(REQ_AT, 200 + k * 64 + 32, 32);
    for (k = 0; k < 70; k++) push(REQ_FREE, 200 + k * 64 + 32, 32);

    // random: allocations, at-allocations, frees at random addresses, bad requests; sizes mostly small
    for (k = 0; k < 1700; k++) begin
      int unsigned r;
      r = $urandom_range(99);
      s = ($urandom_range(9) == 0) ? $urandom_range(65536) : $urandom_range(600);
      if (r < 40) push(REQ_ALLOC, $urandom, s);
      else if (r < 60) push(REQ_AT, $urandom_range(1) ? ($urandom & 16'hFFF8) : $urandom, s);
      else if (r < 90) push(REQ_FREE, $urandom_range(3) ? ($urandom & 16'hFFF0) : $urandom,
                             $urandom_range(3) ? (s & 17'h1FFF8) : s);
      else if (r < 93) push(REQ_BAD, $urandom, $urandom_range(131071));
      else push(REQ_FREE, 0, 65536);
      if (k == 400) for (int j = 0; j < 60; j++) push(REQ_ALLOC, 0, 16);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // last stretch runs with no idling on either side
    wait (n_sent > 1500);
    calm = 1;
    wait (pending_reqs.size() == 0);
    stim_done = 1;
    wait (expected_res.size() == 0 && !s_tvalid);
    repeat (300) @(posedge clk);
    $display("%0d requests checked, %0d granted/ok, %0d table-full answers",
             n_checked, n_ok, n_full);
    if (errors == 0 && expected_res.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/ffra_pkg.sv
rtl/ffra_dp.sv
rtl/ffra_ctrl.sv
rtl/first_fit_range_allocator_unit.sv
bench/tb.sv
